[hw/rtl/hbs_pkg.sv]
// ----------------------------------------------------------------------------
// hbs_pkg
// Shared types and constants of the height map bilinear sampler.
// ----------------------------------------------------------------------------
package hbs_pkg;

    localparam int COORD_W  = 19;
    localparam int SAMPLE_W = 8;
    localparam int SCALE_W  = 16;
    localparam int HEIGHT_W = 24;
    localparam int FRAC_W   = 8;
    localparam int IPART_W  = 10;
    localparam int FACTOR_W = 9;
    localparam int WEIGHT_W = 17;
    localparam int ACC_W    = 24;
    localparam int PROD_W   = ACC_W + SCALE_W;

    localparam logic [1:0] KIND_WRITE    = 2'd0;
    localparam logic [1:0] KIND_BILINEAR = 2'd1;
    localparam logic [1:0] KIND_POINT    = 2'd2;

    localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd256;

    typedef struct packed {
        logic clear;
        logic issue;
        logic scale;
    } blend_ctrl_t;

endpackage

[hw/rtl/hbs_sample_mem.sv]
// ----------------------------------------------------------------------------
// hbs_sample_mem
// Single-port sample memory with registered read data.
// ----------------------------------------------------------------------------
module hbs_sample_mem #(
    parameter int ADDR_W = 20
) (
    input  logic                          aclk,
    input  logic                          we,
    input  logic [ADDR_W-1:0]             addr,
    input  logic [hbs_pkg::SAMPLE_W-1:0]  wdata,
    output logic [hbs_pkg::SAMPLE_W-1:0]  rdata
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [hbs_pkg::SAMPLE_W-1:0] mem [0:DEPTH-1];
    logic [hbs_pkg::SAMPLE_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/hbs_blend.sv]
// ----------------------------------------------------------------------------
// hbs_blend
// Weighted accumulation of the neighbor samples and final height scaling.
// ----------------------------------------------------------------------------
module hbs_blend (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  hbs_pkg::blend_ctrl_t          ctrl,
    input  logic [hbs_pkg::FACTOR_W-1:0]  wx,
    input  logic [hbs_pkg::FACTOR_W-1:0]  wz,
    input  logic [hbs_pkg::SAMPLE_W-1:0]  rdata,
    input  logic [hbs_pkg::SCALE_W-1:0]   gain,
    output logic [hbs_pkg::HEIGHT_W-1:0]  height
);

    logic [hbs_pkg::WEIGHT_W-1:0]  weight_reg;
    logic                          tap_reg;
    logic [hbs_pkg::ACC_W-1:0]     acc_reg;
    logic [hbs_pkg::PROD_W-1:0]    prod_reg;
    logic [2*hbs_pkg::FACTOR_W-1:0] weight_full;
    logic [hbs_pkg::SAMPLE_W+hbs_pkg::WEIGHT_W-1:0] term;

    assign weight_full = wx * wz;
    assign term        = rdata * weight_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tap_reg <= 1'b0;
        end else begin
            tap_reg <= ctrl.issue;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.issue) begin
            weight_reg <= weight_full[hbs_pkg::WEIGHT_W-1:0];
        end
        if (ctrl.clear) begin
            acc_reg <= '0;
        end else if (tap_reg) begin
            acc_reg <= acc_reg + term[hbs_pkg::ACC_W-1:0];
        end
        if (ctrl.scale) begin
            prod_reg <= acc_reg * gain;
        end
    end

    assign height = prod_reg[hbs_pkg::PROD_W-1 -: hbs_pkg::HEIGHT_W];

endmodule

[hw/rtl/heightmap_bilinear_sampler_top.sv]
// ----------------------------------------------------------------------------
// heightmap_bilinear_sampler_top
// Square 8-bit height map with sample writes, point and bilinear queries.
// ----------------------------------------------------------------------------
//  channel  ports                                         direction
//  s_       s_kind s_coord_x s_coord_z s_sample_value    in  (valid/ready)
//  m_       m_height m_out_of_range                       out (valid/ready)
//  cfg_     cfg_wr_en cfg_wr_data (height scale)          in  (write only)
//
//  One item at a time. A write passes through a write state; an ignored item
//  is dropped in idle. A point query reads one sample; for a bilinear query the
//  four neighbor reads share the one port of the sample memory. An accumulate
//  step and a scale step follow. An out-of-range query goes straight to scale.
//  A result waits in the output register; a new item is taken meanwhile,
//  but the next result waits for that register to free up.
//  Reset clears control and sets the scale to 1.0; samples stay undefined.
// ----------------------------------------------------------------------------
module heightmap_bilinear_sampler_top #(
    parameter int MAP_SIZE = 1024
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [hbs_pkg::SCALE_W-1:0]   cfg_wr_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [1:0]                    s_kind,
    input  logic signed [hbs_pkg::COORD_W-1:0] s_coord_x,
    input  logic signed [hbs_pkg::COORD_W-1:0] s_coord_z,
    input  logic [hbs_pkg::SAMPLE_W-1:0]  s_sample_value,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [hbs_pkg::HEIGHT_W-1:0]  m_height,
    output logic                          m_out_of_range
);

    localparam int IDX_W  = (MAP_SIZE > 2) ? $clog2(MAP_SIZE) : 1;
    localparam int ADDR_W = 2 * IDX_W;
    localparam int LAST   = MAP_SIZE - 1;
    localparam int CMP_W  = 13;
    localparam int FCMP_W = 21;
    localparam logic [CMP_W-1:0]  LAST_IDX   = CMP_W'(LAST);
    localparam logic [FCMP_W-1:0] FRAC_LIMIT = FCMP_W'(LAST * 256);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_WRITE = 3'd1;
    localparam logic [2:0] ST_READ  = 3'd2;
    localparam logic [2:0] ST_DRAIN = 3'd3;
    localparam logic [2:0] ST_SCALE = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;

    logic [2:0] state_reg, state_next;
    logic [1:0] cnt_reg, cnt_next;
    logic [1:0] last_cnt_reg;
    logic [hbs_pkg::SCALE_W-1:0] scale_reg;

    logic [IDX_W-1:0] col_lo_reg, col_hi_reg, row_lo_reg, row_hi_reg;
    logic [hbs_pkg::FRAC_W-1:0] dx_reg, dz_reg;
    logic [hbs_pkg::SAMPLE_W-1:0] val_reg;
    logic oor_reg;

    logic m_valid_reg;
    logic [hbs_pkg::HEIGHT_W-1:0] m_height_reg;
    logic m_oor_reg;

    logic accept;
    logic x_neg, z_neg;
    logic [CMP_W-1:0] xl_w, zl_w, xh_w, zh_w;
    logic pt_oor, bl_oor;
    logic [hbs_pkg::FRAC_W-1:0] dx_in, dz_in;
    logic is_query;

    logic [IDX_W-1:0] rd_col, rd_row;
    logic [hbs_pkg::FACTOR_W-1:0] wx, wz;
    logic mem_we;
    logic [ADDR_W-1:0] mem_addr;
    logic [hbs_pkg::SAMPLE_W-1:0] mem_rdata;
    hbs_pkg::blend_ctrl_t ctrl;
    logic [hbs_pkg::HEIGHT_W-1:0] blend_height;
    logic out_free;

    assign accept   = s_valid && s_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign out_free = !m_valid_reg || m_ready;

    // decode position at accept
    assign x_neg = s_coord_x[hbs_pkg::COORD_W-1];
    assign z_neg = s_coord_z[hbs_pkg::COORD_W-1];
    assign xl_w  = CMP_W'(s_coord_x[hbs_pkg::COORD_W-2 -: hbs_pkg::IPART_W]);
    assign zl_w  = CMP_W'(s_coord_z[hbs_pkg::COORD_W-2 -: hbs_pkg::IPART_W]);
    assign xh_w  = (xl_w >= LAST_IDX) ? LAST_IDX : xl_w + CMP_W'(1);
    assign zh_w  = (zl_w >= LAST_IDX) ? LAST_IDX : zl_w + CMP_W'(1);
    assign pt_oor = x_neg || z_neg || (xl_w > LAST_IDX) || (zl_w > LAST_IDX);
    assign bl_oor = x_neg || z_neg
                 || (FCMP_W'(s_coord_x[hbs_pkg::COORD_W-2:0]) > FRAC_LIMIT)
                 || (FCMP_W'(s_coord_z[hbs_pkg::COORD_W-2:0]) > FRAC_LIMIT);
    assign is_query = (s_kind == hbs_pkg::KIND_BILINEAR) || (s_kind == hbs_pkg::KIND_POINT);
    assign dx_in = (s_kind == hbs_pkg::KIND_BILINEAR) ? s_coord_x[hbs_pkg::FRAC_W-1:0] : '0;
    assign dz_in = (s_kind == hbs_pkg::KIND_BILINEAR) ? s_coord_z[hbs_pkg::FRAC_W-1:0] : '0;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        ctrl       = '0;
        unique case (state_reg)
            ST_IDLE: begin
                cnt_next = '0;
                if (accept) begin
                    ctrl.clear = is_query;
                    case (s_kind)
                        hbs_pkg::KIND_WRITE:    state_next = pt_oor ? ST_IDLE : ST_WRITE;
                        hbs_pkg::KIND_BILINEAR: state_next = bl_oor ? ST_SCALE : ST_READ;
                        hbs_pkg::KIND_POINT:    state_next = pt_oor ? ST_SCALE : ST_READ;
                        default:                state_next = ST_IDLE;
                    endcase
                end
            end
            ST_WRITE: begin
                state_next = ST_IDLE;
            end
            ST_READ: begin
                ctrl.issue = 1'b1;
                cnt_next   = cnt_reg + 2'd1;
                if (cnt_reg == last_cnt_reg) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_SCALE;
            end
            ST_SCALE: begin
                ctrl.scale = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            scale_reg   <= hbs_pkg::SCALE_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (cfg_wr_en) begin
                scale_reg <= cfg_wr_data;
            end
            if (state_reg == ST_OUT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            col_lo_reg   <= IDX_W'(xl_w);
            col_hi_reg   <= IDX_W'(xh_w);
            row_lo_reg   <= IDX_W'(zl_w);
            row_hi_reg   <= IDX_W'(zh_w);
            dx_reg       <= dx_in;
            dz_reg       <= dz_in;
            val_reg      <= s_sample_value;
            oor_reg      <= (s_kind == hbs_pkg::KIND_BILINEAR) ? bl_oor : pt_oor;
            last_cnt_reg <= (s_kind == hbs_pkg::KIND_BILINEAR) ? 2'd3 : 2'd0;
        end
        if (state_reg == ST_OUT && out_free) begin
            m_height_reg <= oor_reg ? '0 : blend_height;
            m_oor_reg    <= oor_reg;
        end
    end

    // neighbor order: low/low, high/low, low/high, high/high
    assign rd_col = cnt_reg[0] ? col_hi_reg : col_lo_reg;
    assign rd_row = cnt_reg[1] ? row_hi_reg : row_lo_reg;
    assign wx = cnt_reg[0] ? hbs_pkg::FACTOR_W'(dx_reg)
                           : hbs_pkg::FACTOR_W'(256) - hbs_pkg::FACTOR_W'(dx_reg);
    assign wz = cnt_reg[1] ? hbs_pkg::FACTOR_W'(dz_reg)
                           : hbs_pkg::FACTOR_W'(256) - hbs_pkg::FACTOR_W'(dz_reg);

    assign mem_we   = (state_reg == ST_WRITE);
    assign mem_addr = {rd_row, rd_col};

    hbs_sample_mem #(
        .ADDR_W (ADDR_W)
    ) u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (val_reg),
        .rdata (mem_rdata)
    );

    hbs_blend u_blend (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .ctrl         (ctrl),
        .wx           (wx),
        .wz           (wz),
        .rdata        (mem_rdata),
        .gain         (scale_reg),
        .height       (blend_height)
    );

    assign m_valid        = m_valid_reg;
    assign m_height       = m_height_reg;
    assign m_out_of_range = m_oor_reg;

endmodule

[hw/rtl/hbs_checker.sv]
// ----------------------------------------------------------------------------
// hbs_checker
// Port-level checks of the height map bilinear sampler.
// ----------------------------------------------------------------------------
module hbs_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic [1:0]                    s_kind,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [hbs_pkg::HEIGHT_W-1:0]  m_height,
    input logic                          m_out_of_range
);

    a_query_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_kind == hbs_pkg::KIND_BILINEAR
                             || s_kind == hbs_pkg::KIND_POINT)) |=> !s_ready)
        else $error("query item did not block the input");

    a_oor_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_out_of_range) |-> (m_height == '0))
        else $error("out-of-range result carries a height");

    a_result_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> s_ready)
        else $error("result shown while an item is still in work");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_height)
                                   && $stable(m_out_of_range)))
        else $error("stalled result changed");

endmodule

bind heightmap_bilinear_sampler_top hbs_checker u_hbs_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .s_kind         (s_kind),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_height       (m_height),
    .m_out_of_range (m_out_of_range)
);

[tb/hbs_result_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbs_result_checker
// Watches the item and result channels of the height map sampler. It keeps
// its own copy of the sample map and the height scale and works out the
// height of every accepted query. Each result is compared with the oldest
// outstanding height.
// ----------------------------------------------------------------------------
module hbs_result_checker #(
    parameter int MAP_SIZE = 1024
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [hbs_pkg::SCALE_W-1:0]         cfg_wr_data,
    input  logic                                s_valid,
    input  logic                                s_ready,
    input  logic [1:0]                          s_kind,
    input  logic signed [hbs_pkg::COORD_W-1:0]  s_coord_x,
    input  logic signed [hbs_pkg::COORD_W-1:0]  s_coord_z,
    input  logic [hbs_pkg::SAMPLE_W-1:0]        s_sample_value,
    input  logic                                m_valid,
    input  logic                                m_ready,
    input  logic [hbs_pkg::HEIGHT_W-1:0]        m_height,
    input  logic                                m_out_of_range,
    output int                                  mismatch_count,
    output int                                  outstanding
);

    localparam int HEIGHT_W = hbs_pkg::HEIGHT_W;
    localparam int SAMPLE_W = hbs_pkg::SAMPLE_W;
    localparam int SCALE_W  = hbs_pkg::SCALE_W;
    localparam int FRAC_W   = hbs_pkg::FRAC_W;
    localparam logic [1:0] KIND_WRITE    = hbs_pkg::KIND_WRITE;
    localparam logic [1:0] KIND_BILINEAR = hbs_pkg::KIND_BILINEAR;
    localparam logic [1:0] KIND_POINT    = hbs_pkg::KIND_POINT;
    localparam logic [SCALE_W-1:0] SCALE_RESET = hbs_pkg::SCALE_RESET;

    localparam int LAST = MAP_SIZE - 1;

    typedef struct packed {
        logic [HEIGHT_W-1:0] height;
        logic                out_of_range;
    } height_result_t;

    logic [SAMPLE_W-1:0] height_map [int];
    logic [SCALE_W-1:0]  scale;
    height_result_t      expected_heights [$];

    function automatic longint tap(input int col, input int row);
        int key;
        key = row * MAP_SIZE + col;
        if (height_map.exists(key)) return longint'(height_map[key]);
        return 0;
    endfunction

    function automatic height_result_t blend_height(input int x, input int z);
        height_result_t r;
        int xl, zl, xh, zh;
        longint dx, dz, ex, ez, acc;
        r = '0;
        if (x < 0 || z < 0 || x > LAST * 256 || z > LAST * 256) begin
            r.out_of_range = 1'b1;
            return r;
        end
        xl = x >> FRAC_W;
        zl = z >> FRAC_W;
        xh = (xl + 1 > LAST) ? LAST : xl + 1;
        zh = (zl + 1 > LAST) ? LAST : zl + 1;
        dx = x & 255;
        dz = z & 255;
        ex = 256 - dx;
        ez = 256 - dz;
        acc = tap(xl, zl) * ex * ez + tap(xh, zl) * dx * ez
            + tap(xl, zh) * ex * dz + tap(xh, zh) * dx * dz;
        r.height = HEIGHT_W'((acc * longint'(scale)) >> 16);
        return r;
    endfunction

    function automatic height_result_t point_height(input int x, input int z);
        height_result_t r;
        r = '0;
        if (x < 0 || z < 0 || (x >> FRAC_W) > LAST || (z >> FRAC_W) > LAST) begin
            r.out_of_range = 1'b1;
            return r;
        end
        r.height = HEIGHT_W'(tap(x >> FRAC_W, z >> FRAC_W) * longint'(scale));
        return r;
    endfunction

    always @(posedge aclk) begin : watch_channels
        height_result_t want;
        int x, z, errs;
        errs = 0;
        if (!aresetn) begin
            scale = SCALE_RESET;
            height_map.delete();
            expected_heights.delete();
        end else begin
            if (cfg_wr_en) scale = cfg_wr_data;
            if (s_valid && s_ready) begin
                x = s_coord_x;
                z = s_coord_z;
                case (s_kind)
                    KIND_WRITE: begin
                        if (x >= 0 && z >= 0 && (x >> FRAC_W) <= LAST && (z >> FRAC_W) <= LAST)
                            height_map[(z >> FRAC_W) * MAP_SIZE + (x >> FRAC_W)] = s_sample_value;
                    end
                    KIND_BILINEAR: expected_heights.push_back(blend_height(x, z));
                    KIND_POINT:    expected_heights.push_back(point_height(x, z));
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (expected_heights.size() == 0) begin
                    $error("unexpected result: height %0d, out_of_range %0b",
                           m_height, m_out_of_range);
                    errs++;
                end else begin
                    want = expected_heights.pop_front();
                    if (m_height !== want.height) begin
                        $error("height: expected %0d, got %0d", want.height, m_height);
                        errs++;
                    end
                    if (m_out_of_range !== want.out_of_range) begin
                        $error("out_of_range: expected %0b, got %0b",
                               want.out_of_range, m_out_of_range);
                        errs++;
                    end
                end
            end
        end
        mismatch_count <= mismatch_count + errs;
        outstanding    <= expected_heights.size();
    end

endmodule

[tb/tb_heightmap_bilinear_sampler_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_heightmap_bilinear_sampler_top
// Drives sample writes, point and bilinear queries into the sampler under
// several height scales. Queries only touch 2x2 patches that were written
// first; out-of-range and dropped items are mixed in. Results are checked
// by hbs_result_checker.
// ----------------------------------------------------------------------------
module tb_heightmap_bilinear_sampler_top;

    localparam int COORD_W  = hbs_pkg::COORD_W;
    localparam int SCALE_W  = hbs_pkg::SCALE_W;
    localparam int SAMPLE_W = hbs_pkg::SAMPLE_W;
    localparam int HEIGHT_W = hbs_pkg::HEIGHT_W;
    localparam logic [1:0] KIND_WRITE    = hbs_pkg::KIND_WRITE;
    localparam logic [1:0] KIND_BILINEAR = hbs_pkg::KIND_BILINEAR;
    localparam logic [1:0] KIND_POINT    = hbs_pkg::KIND_POINT;
    localparam logic [SCALE_W-1:0] SCALE_RESET = hbs_pkg::SCALE_RESET;

    localparam int MAP_SIZE    = 1024;
    localparam int LAST        = MAP_SIZE - 1;
    localparam int EDGE_Q      = LAST * 256;
    localparam int COORD_MAX   = (1 << (COORD_W - 1)) - 1;
    localparam int COORD_MIN   = -(1 << (COORD_W - 1));
    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int QUERY_ITEMS = 1050;
    localparam int CYCLE_LIMIT = 400000;

    logic                         aclk;
    logic                         aresetn;
    logic                         cfg_wr_en;
    logic [SCALE_W-1:0]           cfg_wr_data;
    logic                         s_valid;
    logic                         s_ready;
    logic [1:0]                   s_kind;
    logic signed [COORD_W-1:0]    s_coord_x;
    logic signed [COORD_W-1:0]    s_coord_z;
    logic [SAMPLE_W-1:0]          s_sample_value;
    logic                         m_valid;
    logic                         m_ready;
    logic [HEIGHT_W-1:0]          m_height;
    logic                         m_out_of_range;

    int mismatch_count;
    int outstanding;
    int cycles  = 0;
    int counted = 0;
    bit calm    = 1'b0;
    int patch_col [$];
    int patch_row [$];

    heightmap_bilinear_sampler_top #(
        .MAP_SIZE(MAP_SIZE)
    ) uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_kind        (s_kind),
        .s_coord_x     (s_coord_x),
        .s_coord_z     (s_coord_z),
        .s_sample_value(s_sample_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_height      (m_height),
        .m_out_of_range(m_out_of_range)
    );

    hbs_result_checker #(
        .MAP_SIZE(MAP_SIZE)
    ) u_result_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_kind        (s_kind),
        .s_coord_x     (s_coord_x),
        .s_coord_z     (s_coord_z),
        .s_sample_value(s_sample_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_height      (m_height),
        .m_out_of_range(m_out_of_range),
        .mismatch_count(mismatch_count),
        .outstanding   (outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (calm) m_ready <= 1'b1;
        else m_ready <= ($urandom_range(99) >= 6);
    end

    task automatic send_item(input logic [1:0] kind, input int x, input int z, input int value);
        while (!calm && $urandom_range(99) < 6) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_kind         <= kind;
        s_coord_x      <= COORD_W'(x);
        s_coord_z      <= COORD_W'(z);
        s_sample_value <= SAMPLE_W'(value);
        do @(negedge aclk); while (!s_ready);
        @(posedge aclk);
        if (!(kind == KIND_UNUSED || (kind == KIND_WRITE && (x < 0 || z < 0)))) counted++;
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        do @(negedge aclk); while (outstanding != 0);
        repeat (16) @(posedge aclk);
    endtask

    // write all four corners of the cell so a blend inside it reads only written samples
    task automatic lay_patch(input int c, input int r, input int v0, input int v1,
                             input int v2, input int v3);
        int c1, r1;
        c1 = (c < LAST) ? c + 1 : LAST;
        r1 = (r < LAST) ? r + 1 : LAST;
        send_item(KIND_WRITE, c * 256 + $urandom_range(255), r * 256 + $urandom_range(255), v0);
        send_item(KIND_WRITE, c1 * 256 + $urandom_range(255), r * 256 + $urandom_range(255), v1);
        send_item(KIND_WRITE, c * 256 + $urandom_range(255), r1 * 256 + $urandom_range(255), v2);
        send_item(KIND_WRITE, c1 * 256 + $urandom_range(255), r1 * 256 + $urandom_range(255), v3);
        patch_col.push_back(c);
        patch_row.push_back(r);
    endtask

    task automatic query_patch(input logic [1:0] kind);
        int p, c, r;
        p = $urandom_range(patch_col.size() - 1);
        c = patch_col[p];
        r = patch_row[p];
        if (kind == KIND_POINT) begin
            if (c < LAST) c = c + $urandom_range(1);
            if (r < LAST) r = r + $urandom_range(1);
        end
        send_item(kind, c * 256 + $urandom_range(255), r * 256 + $urandom_range(255),
                  $urandom_range(255));
    endtask

    function automatic int pick_place();
        int k;
        k = $urandom_range(9);
        if (k == 0) return 0;
        if (k == 1) return LAST;
        if (k == 2) return LAST - 1;
        return $urandom_range(LAST);
    endfunction

    task automatic random_items(input int quota);
        int stop, pick, p, bad;
        logic [1:0] kind;
        logic signed [COORD_W-1:0] any;
        stop = counted + quota;
        while (counted < stop) begin
            pick = $urandom_range(99);
            any  = COORD_W'($urandom);
            if (pick < 8) begin
                lay_patch(pick_place(), pick_place(), $urandom_range(255), $urandom_range(255),
                          $urandom_range(255), $urandom_range(255));
            end else if (pick < 13) begin
                p = $urandom_range(patch_col.size() - 1);
                send_item(KIND_WRITE, patch_col[p] * 256 + $urandom_range(255),
                          patch_row[p] * 256 + $urandom_range(255), $urandom_range(255));
            end else if (pick < 53) begin
                query_patch(KIND_BILINEAR);
            end else if (pick < 78) begin
                query_patch(KIND_POINT);
            end else if (pick < 92) begin
                kind = pick[0] ? KIND_BILINEAR : KIND_POINT;
                if (kind == KIND_BILINEAR && $urandom_range(1) == 1)
                    bad = $urandom_range(COORD_MAX, EDGE_Q + 1);
                else
                    bad = -int'($urandom_range(-COORD_MIN, 1));
                if ($urandom_range(1) == 1) send_item(kind, bad, int'(any), $urandom_range(255));
                else send_item(kind, int'(any), bad, $urandom_range(255));
            end else if (pick < 96) begin
                send_item(KIND_UNUSED, $urandom, int'(any), $urandom_range(255));
            end else begin
                send_item(KIND_WRITE, -int'($urandom_range(-COORD_MIN, 1)), int'(any),
                          $urandom_range(255));
            end
        end
    endtask

    initial begin
        logic [SCALE_W-1:0] scale_plan [6];
        aresetn        = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_wr_data    = '0;
        s_valid        = 1'b0;
        s_kind         = KIND_WRITE;
        s_coord_x      = '0;
        s_coord_z      = '0;
        s_sample_value = '0;
        m_ready        = 1'b0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        lay_patch(0, 0, 0, 255, 255, 0);
        lay_patch(LAST - 1, LAST - 1, 255, 255, 255, 255);
        send_item(KIND_BILINEAR, 0, 0, 0);
        send_item(KIND_BILINEAR, 255, 255, 0);
        send_item(KIND_BILINEAR, 128, 64, 0);
        send_item(KIND_BILINEAR, EDGE_Q, EDGE_Q, 0);
        send_item(KIND_BILINEAR, EDGE_Q - 1, EDGE_Q - 128, 0);
        send_item(KIND_BILINEAR, EDGE_Q + 1, 0, 0);
        send_item(KIND_BILINEAR, COORD_MAX, COORD_MAX, 0);
        send_item(KIND_BILINEAR, -1, 0, 0);
        send_item(KIND_POINT, COORD_MAX, COORD_MAX, 0);
        send_item(KIND_POINT, 256, 0, 0);
        send_item(KIND_POINT, 0, COORD_MIN, 0);
        send_item(KIND_UNUSED, 0, 0, 255);
        send_item(KIND_WRITE, -1, 0, 77);
        send_item(KIND_WRITE, 0, COORD_MIN, 77);
        send_item(KIND_POINT, 0, 0, 0);

        scale_plan = '{16'hFFFF, 16'h0000, 16'h0001, 16'h0000, 16'h0000, SCALE_RESET};
        scale_plan[3] = SCALE_W'($urandom);
        scale_plan[4] = SCALE_W'($urandom);
        foreach (scale_plan[i]) begin
            settle();
            cfg_wr_en   <= 1'b1;
            cfg_wr_data <= scale_plan[i];
            @(posedge aclk);
            cfg_wr_en <= 1'b0;
            calm = (i == 2);
            random_items(QUERY_ITEMS / 6);
        end
        calm = 1'b0;
        settle();

        if (mismatch_count == 0 && outstanding == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

[heightmap_bilinear_sampler_top.f]
hw/rtl/hbs_pkg.sv
hw/rtl/hbs_sample_mem.sv
hw/rtl/hbs_blend.sv
hw/rtl/heightmap_bilinear_sampler_top.sv
hw/rtl/hbs_checker.sv
tb/hbs_result_checker.sv
tb/tb_heightmap_bilinear_sampler_top.sv
